@@ src/tgcr_pkg.sv @@
// Shared types, constants and the 5x8 font table for the glyph column renderer.
package tgcr_pkg;

   localparam logic [6:0] FIRST_CODE  = 7'h20;
   localparam int         GLYPH_CNT   = 96;
   localparam logic [2:0] LAST_COL    = 3'd4;
   localparam logic [3:0] GLYPH_ROWS  = 4'd8;

   // configuration register indexes
   localparam logic CSR_START_COLUMN = 1'b0;
   localparam logic CSR_START_ROW    = 1'b1;

   // one classified character waiting for the column engine
   typedef struct packed {
      logic [6:0] glyph;
      logic       first;
      logic       last;
   } item_type;

   // each entry holds columns 0..4 from the high byte down
   localparam logic [39:0] FONT_ROM [0:GLYPH_CNT-1] = '{
      40'h0000000000, 40'h00005f0000, 40'h0007000700, 40'h147f147f14,
      40'h242a7f2a12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
      40'h001c224100, 40'h0041221c00, 40'h14083e0814, 40'h08083e0808,
      40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
      40'h3e5149453e, 40'h00427f4000, 40'h4261514946, 40'h2141454b31,
      40'h1814127f10, 40'h2745454539, 40'h3c4a494930, 40'h0171090503,
      40'h3649494936, 40'h064949291e, 40'h0036360000, 40'h0056360000,
      40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
      40'h324979413e, 40'h7e1111117e, 40'h7f49494936, 40'h3e41414122,
      40'h7f4141221c, 40'h7f49494941, 40'h7f09090901, 40'h3e4149497a,
      40'h7f0808087f, 40'h00417f4100, 40'h2040413f01, 40'h7f08142241,
      40'h7f40404040, 40'h7f020c027f, 40'h7f0408107f, 40'h3e4141413e,
      40'h7f09090906, 40'h3e4151215e, 40'h7f09192946, 40'h4649494931,
      40'h01017f0101, 40'h3f4040403f, 40'h1f2040201f, 40'h3f4038403f,
      40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007f414100,
      40'h0204081020, 40'h0041417f00, 40'h0402010204, 40'h4040404040,
      40'h0001020400, 40'h2054545478, 40'h7f48444438, 40'h3844444420,
      40'h384444487f, 40'h3854545418, 40'h087e090102, 40'h0c5252523e,
      40'h7f08040478, 40'h00447d4000, 40'h2040443d00, 40'h7f10284400,
      40'h00417f4000, 40'h7c04180478, 40'h7c08040478, 40'h3844444438,
      40'h7c14141408, 40'h081414187c, 40'h7c08040408, 40'h4854545420,
      40'h043f444020, 40'h3c4040207c, 40'h1c2040201c, 40'h3c4030403c,
      40'h4428102844, 40'h0c5050503c, 40'h4464544c44, 40'h0008364100,
      40'h00007f0000, 40'h0041360800, 40'h1008081008, 40'h0006090906
   };

endpackage

@@ src/tgcr_front.sv @@
// Input side: takes character beats, maps codes to glyph indexes, queues them.
module tgcr_front
   import tgcr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic [6:0] char_code,
   input  logic       first_of_string,
   input  logic       last_of_string,
   input  logic       in_valid,
   output logic       in_ready,
   output logic       q_valid,
   output item_type   q_item,
   input  logic       q_pop
);

   item_type    q_ff [0:1];
   item_type    entry_in;
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        push;
   logic        pop;

   assign in_ready = (count_ff != 2'd2);
   assign q_valid  = (count_ff != 2'd0);
   assign q_item   = q_ff[rd_ptr_ff];
   assign push     = in_valid && in_ready;
   assign pop      = q_pop && q_valid;

   always_comb begin
      // codes below the font range render as space
      entry_in.glyph = (char_code >= FIRST_CODE) ? (char_code - FIRST_CODE) : 7'd0;
      entry_in.first = first_of_string;
      entry_in.last  = last_of_string;
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= entry_in;
      end
   end

endmodule

@@ src/tgcr_back.sv @@
// Column engine: walks five glyph columns per item, tracks cursor and line row.
module tgcr_back
   import tgcr_pkg::*;
#(
   parameter int SCREEN_WIDTH  = 128,
   parameter int SCREEN_HEIGHT = 64
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic [6:0] start_column,
   input  logic [5:0] start_row,
   input  logic       q_valid,
   input  item_type   q_item,
   output logic       q_pop,
   output logic       out_valid,
   input  logic       out_ready,
   output logic [6:0] column_x,
   output logic [6:0] top_row,
   output logic [7:0] pixel_bits,
   output logic [7:0] row_mask,
   output logic       show_frame,
   output logic       last_column
);

   localparam int ROW_MAX = (SCREEN_HEIGHT > 63) ? SCREEN_HEIGHT : 63;
   localparam int ROW_W   = $clog2(ROW_MAX + 9);
   localparam logic [ROW_W-1:0] SH_L = ROW_W'(SCREEN_HEIGHT);
   localparam logic [10:0]      SW_L = 11'(SCREEN_WIDTH);

   logic             active_ff, active_in;
   logic [6:0]       glyph_ff, glyph_in;
   logic             last_ff, last_in;
   logic [2:0]       col_ff, col_in;
   logic [6:0]       cursor_ff, cursor_in;
   logic [ROW_W-1:0] row_ff, row_in;

   logic             out_valid_ff, out_valid_in;
   logic [6:0]       column_x_ff;
   logic [6:0]       top_row_ff;
   logic [7:0]       pixel_bits_ff;
   logic [7:0]       row_mask_ff;
   logic             show_frame_ff;
   logic             last_column_ff;

   logic             issue;
   logic             done;
   logic             pop;
   logic [39:0]      font_word;
   logic [5:0]       byte_base;
   logic [7:0]       pixels;
   logic [7:0]       mask;
   logic             col_visible;
   logic [6:0]       cursor_inc;
   logic [ROW_W-1:0] row_step;
   logic [ROW_W-1:0] row_sum;

   assign issue = active_ff && (!out_valid_ff || out_ready);
   assign done  = issue && (col_ff == LAST_COL);
   assign pop   = q_valid && (!active_ff || done);
   assign q_pop = pop;

   always_comb begin
      font_word   = FONT_ROM[glyph_ff];
      byte_base   = {LAST_COL - col_ff, 3'b000};
      pixels      = font_word[byte_base +: 8];
      col_visible = ({4'd0, cursor_ff} < SW_L);
      row_sum     = '0;
      for (int r = 0; r < 8; r++) begin
         row_sum = row_ff + ROW_W'(r);
         mask[r] = col_visible && (row_sum < SH_L);
      end
   end

   always_comb begin
      active_in = active_ff;
      glyph_in  = glyph_ff;
      last_in   = last_ff;
      col_in    = col_ff;
      cursor_in = cursor_ff;
      row_in    = row_ff;
      cursor_inc = cursor_ff + 7'd1;
      row_step   = row_ff + ROW_W'(GLYPH_ROWS);

      if (issue) begin
         col_in    = col_ff + 3'd1;
         cursor_in = cursor_inc;
         // past the right edge: back to the start column, one text line down, capped at the screen height
         if (cursor_inc == 7'd0 || {4'd0, cursor_inc} >= SW_L) begin
            cursor_in = start_column;
            row_in    = (row_step > SH_L) ? SH_L : row_step;
         end
      end
      if (done) begin
         active_in = 1'b0;
      end
      if (pop) begin
         active_in = 1'b1;
         glyph_in  = q_item.glyph;
         last_in   = q_item.last;
         col_in    = 3'd0;
         if (q_item.first) begin
            cursor_in = start_column;
            row_in    = ROW_W'(start_row);
         end
      end

      out_valid_in = out_valid_ff;
      if (issue) begin
         out_valid_in = 1'b1;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         col_ff       <= 3'd0;
         cursor_ff    <= 7'd0;
         row_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         col_ff       <= col_in;
         cursor_ff    <= cursor_in;
         row_ff       <= row_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      glyph_ff <= glyph_in;
      last_ff  <= last_in;
      if (issue) begin
         column_x_ff    <= cursor_ff;
         top_row_ff     <= row_ff[6:0];
         pixel_bits_ff  <= pixels;
         row_mask_ff    <= mask;
         show_frame_ff  <= last_ff && (col_ff == LAST_COL);
         last_column_ff <= (col_ff == LAST_COL);
      end
   end

   assign out_valid   = out_valid_ff;
   assign column_x    = column_x_ff;
   assign top_row     = top_row_ff;
   assign pixel_bits  = pixel_bits_ff;
   assign row_mask    = row_mask_ff;
   assign show_frame  = show_frame_ff;
   assign last_column = last_column_ff;

endmodule

@@ src/text_glyph_column_renderer.sv @@
// Top level of the text glyph column renderer: config registers and the two engines.
//
// Usage:
//   req_ channel: one beat per character. tdata carries the 7-bit code, tuser
//   marks the first character of a string (position reloads from the start
//   registers), tlast the last one (show_frame on its final column).
//   rsp_ channel: five beats per character, one per glyph column, in order.
//   tlast marks the fifth column, tuser carries the frame-show request.
//   csr_ port: csr_we writes csr_wdata to start_column (index 0) or
//   start_row (index 1); write only while no character is in flight.
// A character's beat lands in the queue, is then loaded into the column engine,
//   and its first column is then captured in the output register, once the engine is free.
// Throughput: one column per cycle while rsp_tready holds, set by the
//   single column engine and its output register; the next character is loaded as the last column issues.
// A two-entry queue sits between the input side and the column engine, so
//   input beats keep landing while the receiver stalls; once it fills,
//   req_tready drops. A stalled rsp_ beat holds steady until taken.
// Reset (synchronous) empties the queue, clears the output valid flag, the
//   cursor, the line row and both start registers.
module text_glyph_column_renderer
   import tgcr_pkg::*;
#(
   parameter int SCREEN_WIDTH  = 128,
   parameter int SCREEN_HEIGHT = 64
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [6:0] char_code, [7] zero
   input  logic        req_tuser,   // [0] first_of_string
   input  logic        req_tlast,   // last_of_string
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [6:0] column_x, [13:7] top_row,
                                    // [21:14] pixel_bits, [29:22] row_mask, [31:30] zero
   output logic        rsp_tuser,   // [0] show_frame
   output logic        rsp_tlast,   // last_column
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [6:0]  csr_wdata
);

   logic [6:0] start_column_ff, start_column_in;
   logic [5:0] start_row_ff, start_row_in;
   logic       q_valid;
   item_type   q_item;
   logic       q_pop;
   logic [6:0] column_x;
   logic [6:0] top_row;
   logic [7:0] pixel_bits;
   logic [7:0] row_mask;

   always_comb begin
      start_column_in = start_column_ff;
      start_row_in    = start_row_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_START_COLUMN: start_column_in = csr_wdata;
            CSR_START_ROW:    start_row_in    = csr_wdata[5:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_column_ff <= 7'd0;
         start_row_ff    <= 6'd0;
      end else begin
         start_column_ff <= start_column_in;
         start_row_ff    <= start_row_in;
      end
   end

   tgcr_front u_front (
      .clock           (clock),
      .reset           (reset),
      .char_code       (req_tdata[6:0]),
      .first_of_string (req_tuser),
      .last_of_string  (req_tlast),
      .in_valid        (req_tvalid),
      .in_ready        (req_tready),
      .q_valid         (q_valid),
      .q_item          (q_item),
      .q_pop           (q_pop)
   );

   tgcr_back #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .start_column (start_column_ff),
      .start_row    (start_row_ff),
      .q_valid      (q_valid),
      .q_item       (q_item),
      .q_pop        (q_pop),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .column_x     (column_x),
      .top_row      (top_row),
      .pixel_bits   (pixel_bits),
      .row_mask     (row_mask),
      .show_frame   (rsp_tuser),
      .last_column  (rsp_tlast)
   );

   assign rsp_tdata = {2'b00, row_mask, pixel_bits, top_row, column_x};

endmodule

@@ test/text_glyph_column_renderer_checker.sv @@
// Column predictor and result checker for the glyph column renderer testbench.
module text_glyph_column_renderer_checker
   import tgcr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [6:0] char_code, [7] zero
   input  logic        req_tuser,   // [0] first_of_string
   input  logic        req_tlast,   // last_of_string
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,   // [6:0] column_x, [13:7] top_row,
                                    // [21:14] pixel_bits, [29:22] row_mask, [31:30] zero
   input  logic        rsp_tuser,   // [0] show_frame
   input  logic        rsp_tlast,   // last_column
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [6:0]  csr_wdata,
   output int          fail_count,
   output int          columns_due
);

   localparam int SCREEN_WIDTH  = 128;
   localparam int SCREEN_HEIGHT = 64;
   localparam int GLYPH_COLS    = 5;

   // column 0 in the high byte, column 4 in the low byte
   localparam logic [39:0] GLYPH_FONT [0:95] = '{
      40'h0000000000, 40'h00005f0000, 40'h0007000700, 40'h147f147f14,
      40'h242a7f2a12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
      40'h001c224100, 40'h0041221c00, 40'h14083e0814, 40'h08083e0808,
      40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
      40'h3e5149453e, 40'h00427f4000, 40'h4261514946, 40'h2141454b31,
      40'h1814127f10, 40'h2745454539, 40'h3c4a494930, 40'h0171090503,
      40'h3649494936, 40'h064949291e, 40'h0036360000, 40'h0056360000,
      40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
      40'h324979413e, 40'h7e1111117e, 40'h7f49494936, 40'h3e41414122,
      40'h7f4141221c, 40'h7f49494941, 40'h7f09090901, 40'h3e4149497a,
      40'h7f0808087f, 40'h00417f4100, 40'h2040413f01, 40'h7f08142241,
      40'h7f40404040, 40'h7f020c027f, 40'h7f0408107f, 40'h3e4141413e,
      40'h7f09090906, 40'h3e4151215e, 40'h7f09192946, 40'h4649494931,
      40'h01017f0101, 40'h3f4040403f, 40'h1f2040201f, 40'h3f4038403f,
      40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007f414100,
      40'h0204081020, 40'h0041417f00, 40'h0402010204, 40'h4040404040,
      40'h0001020400, 40'h2054545478, 40'h7f48444438, 40'h3844444420,
      40'h384444487f, 40'h3854545418, 40'h087e090102, 40'h0c5252523e,
      40'h7f08040478, 40'h00447d4000, 40'h2040443d00, 40'h7f10284400,
      40'h00417f4000, 40'h7c04180478, 40'h7c08040478, 40'h3844444438,
      40'h7c14141408, 40'h081414187c, 40'h7c08040408, 40'h4854545420,
      40'h043f444020, 40'h3c4040207c, 40'h1c2040201c, 40'h3c4030403c,
      40'h4428102844, 40'h0c5050503c, 40'h4464544c44, 40'h0008364100,
      40'h00007f0000, 40'h0041360800, 40'h1008081008, 40'h0006090906
   };

   typedef struct packed {
      logic [6:0] column_x;
      logic [6:0] top_row;
      logic [7:0] pixel_bits;
      logic [7:0] row_mask;
      logic       show_frame;
      logic       last_column;
   } column_beat_type;

   logic [6:0]      start_col;
   logic [5:0]      start_row;
   logic [6:0]      cursor;
   logic [6:0]      line_row;
   column_beat_type due_q[$];
   int              mismatches;

   function automatic logic [7:0] visible_rows(logic [6:0] col, logic [6:0] row);
      logic [7:0] mask;
      mask = '0;
      if (int'(col) < SCREEN_WIDTH) begin
         for (int r = 0; r < 8; r++) begin
            if (int'(row) + r < SCREEN_HEIGHT) mask[r] = 1'b1;
         end
      end
      return mask;
   endfunction

   // expands one character into its five expected column beats
   task automatic render_char(input logic [6:0] code, input logic first, input logic last);
      column_beat_type beat;
      logic [6:0]      glyph;
      glyph = (code >= FIRST_CODE) ? code - FIRST_CODE : '0;
      if (first) begin
         cursor   = start_col;
         line_row = {1'b0, start_row};
      end
      for (int c = 0; c < GLYPH_COLS; c++) begin
         beat.column_x    = cursor;
         beat.top_row     = line_row;
         beat.pixel_bits  = GLYPH_FONT[glyph][39 - 8 * c -: 8];
         beat.row_mask    = visible_rows(cursor, line_row);
         beat.show_frame  = last && (c == GLYPH_COLS - 1);
         beat.last_column = (c == GLYPH_COLS - 1);
         due_q.push_back(beat);
         cursor = cursor + 7'd1;
         // wrap to the next text line, which stops at the fully clipped row
         if (cursor == 7'd0) begin
            line_row = (int'(line_row) + 8 > SCREEN_HEIGHT) ? 7'(SCREEN_HEIGHT)
                                                           : line_row + 7'd8;
            cursor   = start_col;
         end
      end
   endtask

   task automatic compare_field(input string name, input int want, input int got);
      if (want != got) begin
         mismatches++;
         $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      end
   endtask

   task automatic check_beat();
      column_beat_type want;
      if (due_q.size() == 0) begin
         mismatches++;
         $display("%0t: unexpected column beat, expected none got tdata %h", $time, rsp_tdata);
      end else begin
         want = due_q.pop_front();
         compare_field("column_x", want.column_x, rsp_tdata[6:0]);
         compare_field("top_row", want.top_row, rsp_tdata[13:7]);
         compare_field("pixel_bits", want.pixel_bits, rsp_tdata[21:14]);
         compare_field("row_mask", want.row_mask, rsp_tdata[29:22]);
         compare_field("tdata padding", 0, rsp_tdata[31:30]);
         compare_field("show_frame", want.show_frame, rsp_tuser);
         compare_field("last_column", want.last_column, rsp_tlast);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         start_col = '0;
         start_row = '0;
         cursor    = '0;
         line_row  = '0;
         due_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) check_beat();
         if (req_tvalid && req_tready) render_char(req_tdata[6:0], req_tuser, req_tlast);
         if (csr_we) begin
            if (csr_addr == CSR_START_COLUMN) start_col = csr_wdata;
            else start_row = csr_wdata[5:0];
         end
      end
      fail_count  <= mismatches;
      columns_due <= due_q.size();
   end

endmodule

@@ test/text_glyph_column_renderer_tb.sv @@
// Testbench top for the glyph column renderer: stimulus, flow control and verdict.
module text_glyph_column_renderer_tb;
   import tgcr_pkg::*;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic [7:0]  req_tdata  = '0;
   logic        req_tuser  = 1'b0;
   logic        req_tlast  = 1'b0;
   logic        rsp_tready = 1'b0;
   logic        csr_we     = 1'b0;
   logic        csr_addr   = CSR_START_COLUMN;
   logic [6:0]  csr_wdata  = '0;
   logic        req_tready;
   logic        rsp_tvalid;
   logic [31:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   int          fail_count;
   int          columns_due;
   bit          idling = 1'b1;

   text_glyph_column_renderer u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   text_glyph_column_renderer_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_we      (csr_we),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .columns_due (columns_due)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // receiver stalls in bursts
   always begin
      @(posedge clock);
      if (idling && $urandom_range(0, 5) == 0) begin
         rsp_tready <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      rsp_tready <= 1'b1;
   end

   task automatic send_char(input logic [6:0] code, input logic first, input logic last);
      if (idling && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, code};
      req_tuser  <= first;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
   endtask

   // sender holds off until every column of the accepted characters is back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (columns_due != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic addr, input logic [6:0] data);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_start(input logic [6:0] col, input logic [5:0] row);
      wait_drained();
      write_reg(CSR_START_COLUMN, col);
      write_reg(CSR_START_ROW, {1'b0, row});
   endtask

   function automatic logic [6:0] pick_code();
      // mostly printable glyphs, some control codes that render as space
      return ($urandom_range(0, 4) == 0) ? 7'($urandom_range(0, 127))
                                         : 7'($urandom_range(32, 127));
   endfunction

   task automatic send_string(input int len, input bit mark_first);
      for (int i = 0; i < len; i++) begin
         send_char(pick_code(), mark_first && i == 0, i == len - 1);
      end
   endtask

   initial begin
      int sent;
      int len;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // straight out of reset, no first mark: continues from column 0, row 0
      send_char(7'h41, 1'b0, 1'b0);
      send_char(7'h00, 1'b0, 1'b0);
      send_char(7'h1f, 1'b0, 1'b0);
      send_char(7'h20, 1'b0, 1'b0);
      send_char(7'h7f, 1'b0, 1'b0);
      send_char(7'h7e, 1'b0, 1'b0);
      send_char(7'h55, 1'b0, 1'b0);
      send_char(7'h2a, 1'b0, 1'b0);
      send_char(7'h48, 1'b1, 1'b1);
      send_char(7'h69, 1'b0, 1'b1);

      // wrap in the middle of a glyph
      set_start(7'd125, 6'd8);
      send_char(7'h57, 1'b1, 1'b0);
      send_char(7'h78, 1'b0, 1'b0);
      send_char(7'h79, 1'b0, 1'b1);

      // last column and lowest start row: line runs off the screen and stays clipped
      set_start(7'd127, 6'd63);
      send_char(7'h23, 1'b1, 1'b1);
      send_char(7'h30, 1'b0, 1'b0);
      send_char(7'h31, 1'b0, 1'b0);
      send_char(7'h32, 1'b0, 1'b1);
      send_char(7'h30, 1'b1, 1'b0);

      // partly clipped line
      set_start(7'd0, 6'd57);
      send_char(7'h4d, 1'b1, 1'b1);
      send_char(7'h40, 1'b0, 1'b0);

      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: set_start(7'd0, 6'd0);
            1: set_start(7'd127, 6'd63);
            default: set_start(($urandom_range(0, 1) == 1) ? 7'($urandom_range(100, 127))
                                                           : 7'($urandom_range(0, 127)),
                               6'($urandom_range(0, 63)));
         endcase
         if (phase == 7) idling = 1'b0;
         sent = 0;
         while (sent < 45) begin
            if ($urandom_range(0, 7) == 0) begin
               send_char(7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
               sent++;
            end else begin
               len = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                 : $urandom_range(1, 12);
               send_string(len, $urandom_range(0, 7) != 0);
               sent += len;
            end
         end
      end

      wait_drained();
      repeat (20) @(posedge clock);
      if (fail_count == 0 && columns_due == 0) begin
         $display("text_glyph_column_renderer verification clean");
      end else begin
         $display("text_glyph_column_renderer verification failed");
      end
      $finish;
   end

   initial begin
      #1000000;
      $display("text_glyph_column_renderer verification failed");
      $finish;
   end

endmodule

@@ files.f @@
src/tgcr_pkg.sv
src/tgcr_front.sv
src/tgcr_back.sv
src/text_glyph_column_renderer.sv
test/text_glyph_column_renderer_checker.sv
test/text_glyph_column_renderer_tb.sv
